/* hdl/csbp_pkg.sv */
// Types and constants shared by the cubic spline bounding profile block.
package csbp_pkg;

    localparam int COEF_W   = 32;
    localparam int LEN_W    = 31;
    localparam int SUM_W    = 34;
    localparam int VAL_W    = 36;
    localparam int GROW_W   = 37;
    localparam int MAG_W    = 64;
    localparam int NUM_W    = 35;
    localparam int DEN_W    = 34;
    localparam int Q_W      = 17;
    localparam int FRAC_W   = 16;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 17;
    localparam int HORNER_STEPS = 3;
    localparam int CTX_LAST = SQ_STEPS + DIV_STEPS + 6;
    localparam int AX_LAT   = CTX_LAST + 2;

    localparam logic [MAG_W-1:0] DBL_BAND = 64'd107374;
    localparam logic signed [COEF_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
        logic signed [SUM_W-1:0]  v1;
    } t_ctx;

    typedef struct packed {
        logic quad;
        logic dbl;
        logic two;
    } t_kind;

    typedef struct packed {
        logic             foot_present;
        logic [LEN_W-1:0] foot_length;
        logic             near_present;
        logic [LEN_W-1:0] near_length;
    } t_shape;

endpackage

/* hdl/csbp_axis.sv */
// Pipelined minimum and maximum of one cubic polynomial over the unit interval.
module csbp_axis (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [csbp_pkg::COEF_W-1:0]   i_c0,
    input  logic signed [csbp_pkg::COEF_W-1:0]   i_c1,
    input  logic signed [csbp_pkg::COEF_W-1:0]   i_c2,
    input  logic signed [csbp_pkg::COEF_W-1:0]   i_c3,
    output logic signed [csbp_pkg::VAL_W-1:0]    o_lo,
    output logic signed [csbp_pkg::VAL_W-1:0]    o_hi
);
    import csbp_pkg::*;

    function automatic logic signed [VAL_W-1:0] hstep(input logic signed [VAL_W-1:0] acc,
                                                      input logic [Q_W-1:0] t,
                                                      input logic signed [COEF_W-1:0] c);
        logic signed [VAL_W+Q_W:0] prod;
        prod = acc * $signed({1'b0, t});
        return VAL_W'(prod >>> FRAC_W) + VAL_W'(c);
    endfunction

    t_ctx r_ctx [0:CTX_LAST];
    logic signed [2*COEF_W-1:0] r_sq;
    logic signed [2*COEF_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= i_c2 * i_c2;
            r_p  <= i_c3 * i_c1;
            r_ctx[0].c0 <= i_c0;
            r_ctx[0].c1 <= i_c1;
            r_ctx[0].c2 <= i_c2;
            r_ctx[0].c3 <= i_c3;
            r_ctx[0].v1 <= SUM_W'(i_c0) + SUM_W'(i_c1) + SUM_W'(i_c2) + SUM_W'(i_c3);
        end
    end

    for (genvar i = 1; i <= CTX_LAST; i++) begin : g_ctx
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[i] <= r_ctx[i-1];
            end
        end
    end

    logic signed [MAG_W+1:0] w_sqe;
    logic signed [MAG_W+1:0] w_pe;
    logic signed [MAG_W+1:0] w_e;
    logic                    w_neg;
    logic [MAG_W-1:0]        w_mag;
    logic                    w_c3z;
    t_kind                   w_kind;

    always_comb begin
        w_sqe = (MAG_W+2)'(r_sq);
        w_pe  = (MAG_W+2)'(r_p);
        w_e   = w_sqe - w_pe - (w_pe <<< 1);
        w_neg = w_e[MAG_W+1];
        w_mag = w_neg ? MAG_W'(-w_e) : MAG_W'(w_e);
        w_c3z = (r_ctx[0].c3 == '0);
        w_kind.quad = w_c3z && (r_ctx[0].c2 != '0);
        w_kind.dbl  = !w_c3z && (w_mag <= DBL_BAND);
        w_kind.two  = !w_c3z && !w_neg && (w_mag > DBL_BAND);
    end

    logic [MAG_W-1:0] r_rn [0:SQ_STEPS];
    logic [MAG_W-1:0] r_rr [0:SQ_STEPS];
    t_kind            r_kd [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rn[0] <= w_mag;
            r_rr[0] <= '0;
            r_kd[0] <= w_kind;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [MAG_W-1:0] BIT = MAG_W'(1) << (MAG_W - 2 - 2*k);
        logic [MAG_W:0] w_trial;
        logic           w_take;
        assign w_trial = {1'b0, r_rr[k]} + {1'b0, BIT};
        assign w_take  = ({1'b0, r_rn[k]} >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_kd[k+1] <= r_kd[k];
                if (w_take) begin
                    r_rn[k+1] <= r_rn[k] - w_trial[MAG_W-1:0];
                    r_rr[k+1] <= (r_rr[k] >> 1) + BIT;
                end else begin
                    r_rn[k+1] <= r_rn[k];
                    r_rr[k+1] <= r_rr[k] >> 1;
                end
            end
        end
    end

    localparam int CI = SQ_STEPS + 1;

    logic signed [NUM_W-1:0] w_s;
    logic signed [NUM_W-1:0] w_c1n;
    logic signed [NUM_W-1:0] w_c2n;
    logic signed [NUM_W-1:0] w_c2w;
    logic signed [NUM_W-1:0] w_c3w;
    logic signed [NUM_W-1:0] r_cn [0:1];
    logic signed [NUM_W-1:0] r_cden;
    logic                    r_ce [0:1];

    assign w_s   = $signed({3'b000, r_rr[SQ_STEPS][COEF_W-1:0]});
    assign w_c1n = -NUM_W'(r_ctx[CI].c1);
    assign w_c2n = -NUM_W'(r_ctx[CI].c2);
    assign w_c2w = NUM_W'(r_ctx[CI].c2);
    assign w_c3w = NUM_W'(r_ctx[CI].c3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cden <= w_c3w + (w_c3w <<< 1);
            r_cn[0] <= w_c2n;
            r_cn[1] <= w_c2n - w_s;
            r_ce[0] <= 1'b0;
            r_ce[1] <= 1'b0;
            if (r_kd[SQ_STEPS].quad) begin
                r_cn[0] <= w_c1n;
                r_cden  <= w_c2w <<< 1;
                r_ce[0] <= 1'b1;
            end else if (r_kd[SQ_STEPS].dbl) begin
                r_ce[0] <= 1'b1;
            end else if (r_kd[SQ_STEPS].two) begin
                r_cn[0] <= w_c2n + w_s;
                r_ce[0] <= 1'b1;
                r_ce[1] <= 1'b1;
            end
        end
    end

    logic [DEN_W-1:0] r_rm [0:DIV_STEPS][0:1];
    logic [Q_W-1:0]   r_q  [0:DIV_STEPS][0:1];
    logic             r_pe [0:DIV_STEPS][0:1];
    logic [DEN_W-1:0] r_dv [0:DIV_STEPS];

    logic signed [NUM_W-1:0] w_dn;
    assign w_dn = r_cden[NUM_W-1] ? -r_cden : r_cden;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= w_dn[DEN_W-1:0];
        end
    end

    for (genvar p = 0; p < 2; p++) begin : g_norm
        logic signed [NUM_W-1:0] w_n;
        assign w_n = r_cden[NUM_W-1] ? -r_cn[p] : r_cn[p];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[0][p] <= w_n[DEN_W-1:0];
                r_q[0][p]  <= '0;
                r_pe[0][p] <= r_ce[p] && (w_dn != '0) && !w_n[NUM_W-1] && (w_n <= w_dn);
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end
        for (genvar p = 0; p < 2; p++) begin : g_lane
            logic [DEN_W:0] w_t;
            logic           w_ge;
            if (j == 0) begin : g_first
                assign w_t = {1'b0, r_rm[j][p]};
            end else begin : g_next
                assign w_t = {r_rm[j][p], 1'b0};
            end
            assign w_ge = (w_t >= {1'b0, r_dv[j]});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rm[j+1][p] <= w_ge ? DEN_W'(w_t - {1'b0, r_dv[j]}) : w_t[DEN_W-1:0];
                    r_q[j+1][p]  <= {r_q[j][p][Q_W-2:0], w_ge};
                    r_pe[j+1][p] <= r_pe[j][p];
                end
            end
        end
    end

    localparam int HI = SQ_STEPS + DIV_STEPS + 3;

    logic signed [VAL_W-1:0] r_h  [0:HORNER_STEPS-1][0:1];
    logic [Q_W-1:0]          r_ht [0:HORNER_STEPS-1][0:1];
    logic                    r_he [0:HORNER_STEPS-1][0:1];

    for (genvar p = 0; p < 2; p++) begin : g_horner
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h[0][p]  <= hstep(VAL_W'(r_ctx[HI].c3), r_q[DIV_STEPS][p], r_ctx[HI].c2);
                r_ht[0][p] <= r_q[DIV_STEPS][p];
                r_he[0][p] <= r_pe[DIV_STEPS][p];
                r_h[1][p]  <= hstep(r_h[0][p], r_ht[0][p], r_ctx[HI+1].c1);
                r_ht[1][p] <= r_ht[0][p];
                r_he[1][p] <= r_he[0][p];
                r_h[2][p]  <= hstep(r_h[1][p], r_ht[1][p], r_ctx[HI+2].c0);
                r_ht[2][p] <= r_ht[1][p];
                r_he[2][p] <= r_he[1][p];
            end
        end
    end

    logic signed [VAL_W-1:0] w_v0;
    logic signed [VAL_W-1:0] w_v1;
    logic signed [VAL_W-1:0] w_lo;
    logic signed [VAL_W-1:0] w_hi;
    logic signed [VAL_W-1:0] r_lo;
    logic signed [VAL_W-1:0] r_hi;

    always_comb begin
        w_v0 = VAL_W'(r_ctx[CTX_LAST].c0);
        w_v1 = VAL_W'(r_ctx[CTX_LAST].v1);
        w_lo = (w_v0 < w_v1) ? w_v0 : w_v1;
        w_hi = (w_v0 < w_v1) ? w_v1 : w_v0;
        for (int p = 0; p < 2; p++) begin
            if (r_he[HORNER_STEPS-1][p]) begin
                if (r_h[HORNER_STEPS-1][p] < w_lo) begin
                    w_lo = r_h[HORNER_STEPS-1][p];
                end
                if (r_h[HORNER_STEPS-1][p] > w_hi) begin
                    w_hi = r_h[HORNER_STEPS-1][p];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= w_lo;
            r_hi <= w_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

/* hdl/cubic_spline_bounding_profile_top.sv */
// Top level of the cubic spline bounding profile block.
// Each input item holds the x and y cubics of one trajectory segment over t in [0,1]
// in Q16.16, with the footprint and vicinity lengths and their presence flags.
// Each item gives exactly one result item: the footprint box and the vicinity box,
// each grown from the extrema of the segment and saturated to 32 bits, or void when
// the shape is absent.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// One item is accepted in every cycle while the pipeline is not held by a stall. The
// depth is set by the 32 one-bit stages of the square root of the discriminant and the
// 17 one-bit stages of the stationary point division.
// When the receiver stalls while a result is waiting, the whole pipeline holds and
// the input stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so no result is offered until new items arrive.
module cubic_spline_bounding_profile_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_x_coef0,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_x_coef1,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_x_coef2,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_x_coef3,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_y_coef0,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_y_coef1,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_y_coef2,
    input  logic signed [csbp_pkg::COEF_W-1:0]  i_y_coef3,
    input  logic                                i_footprint_present,
    input  logic [csbp_pkg::LEN_W-1:0]          i_footprint_length,
    input  logic                                i_vicinity_present,
    input  logic [csbp_pkg::LEN_W-1:0]          i_vicinity_length,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_foot_min_x,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_foot_min_y,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_foot_max_x,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_foot_max_y,
    output logic                                o_foot_void,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_near_min_x,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_near_min_y,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_near_max_x,
    output logic signed [csbp_pkg::COEF_W-1:0]  o_near_max_y,
    output logic                                o_near_void
);
    import csbp_pkg::*;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [GROW_W-1:0] v);
        logic signed [GROW_W-1:0] vmax;
        logic signed [GROW_W-1:0] vmin;
        vmax = GROW_W'(SAT_MAX);
        vmin = GROW_W'(SAT_MIN);
        if (v > vmax) begin
            return SAT_MAX;
        end else if (v < vmin) begin
            return SAT_MIN;
        end
        return v[COEF_W-1:0];
    endfunction

    logic w_en;
    logic r_ovld;

    assign w_en    = !(r_ovld && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_ovld;

    logic signed [VAL_W-1:0] w_xlo;
    logic signed [VAL_W-1:0] w_xhi;
    logic signed [VAL_W-1:0] w_ylo;
    logic signed [VAL_W-1:0] w_yhi;

    csbp_axis u_axis_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_c0  (i_x_coef0),
        .i_c1  (i_x_coef1),
        .i_c2  (i_x_coef2),
        .i_c3  (i_x_coef3),
        .o_lo  (w_xlo),
        .o_hi  (w_xhi)
    );

    csbp_axis u_axis_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_c0  (i_y_coef0),
        .i_c1  (i_y_coef1),
        .i_c2  (i_y_coef2),
        .i_c3  (i_y_coef3),
        .o_lo  (w_ylo),
        .o_hi  (w_yhi)
    );

    logic   r_vld [0:AX_LAT-1];
    t_shape r_sh  [0:AX_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sh[0].foot_present <= i_footprint_present;
            r_sh[0].foot_length  <= i_footprint_length;
            r_sh[0].near_present <= i_vicinity_present;
            r_sh[0].near_length  <= i_vicinity_length;
        end
    end

    for (genvar i = 1; i < AX_LAT; i++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (w_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    t_shape w_sh;
    logic signed [GROW_W-1:0] w_fl;
    logic signed [GROW_W-1:0] w_nl;

    assign w_sh = r_sh[AX_LAT-1];
    assign w_fl = $signed({{(GROW_W-LEN_W){1'b0}}, w_sh.foot_length});
    assign w_nl = $signed({{(GROW_W-LEN_W){1'b0}}, w_sh.near_length});

    logic signed [COEF_W-1:0] r_fminx;
    logic signed [COEF_W-1:0] r_fminy;
    logic signed [COEF_W-1:0] r_fmaxx;
    logic signed [COEF_W-1:0] r_fmaxy;
    logic                     r_fvoid;
    logic signed [COEF_W-1:0] r_nminx;
    logic signed [COEF_W-1:0] r_nminy;
    logic signed [COEF_W-1:0] r_nmaxx;
    logic signed [COEF_W-1:0] r_nmaxy;
    logic                     r_nvoid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_vld[AX_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sh.foot_present) begin
                r_fminx <= sat32(GROW_W'(w_xlo) - w_fl);
                r_fminy <= sat32(GROW_W'(w_ylo) - w_fl);
                r_fmaxx <= sat32(GROW_W'(w_xhi) + w_fl);
                r_fmaxy <= sat32(GROW_W'(w_yhi) + w_fl);
                r_fvoid <= 1'b0;
            end else begin
                r_fminx <= SAT_MAX;
                r_fminy <= SAT_MAX;
                r_fmaxx <= SAT_MIN;
                r_fmaxy <= SAT_MIN;
                r_fvoid <= 1'b1;
            end
            if (w_sh.near_present) begin
                r_nminx <= sat32(GROW_W'(w_xlo) - w_nl);
                r_nminy <= sat32(GROW_W'(w_ylo) - w_nl);
                r_nmaxx <= sat32(GROW_W'(w_xhi) + w_nl);
                r_nmaxy <= sat32(GROW_W'(w_yhi) + w_nl);
                r_nvoid <= 1'b0;
            end else begin
                r_nminx <= SAT_MAX;
                r_nminy <= SAT_MAX;
                r_nmaxx <= SAT_MIN;
                r_nmaxy <= SAT_MIN;
                r_nvoid <= 1'b1;
            end
        end
    end

    assign o_foot_min_x = r_fminx;
    assign o_foot_min_y = r_fminy;
    assign o_foot_max_x = r_fmaxx;
    assign o_foot_max_y = r_fmaxy;
    assign o_foot_void  = r_fvoid;
    assign o_near_min_x = r_nminx;
    assign o_near_min_y = r_nminy;
    assign o_near_max_x = r_nmaxx;
    assign o_near_max_y = r_nmaxy;
    assign o_near_void  = r_nvoid;

endmodule

/* dv/cubic_spline_bounding_profile_top_tb.sv */
// Self-checking testbench of the cubic spline bounding profile block.
`timescale 1ns / 1ps

module cubic_spline_bounding_profile_top_tb;
    import csbp_pkg::*;

    typedef struct packed {
        logic signed [31:0] foot_min_x;
        logic signed [31:0] foot_min_y;
        logic signed [31:0] foot_max_x;
        logic signed [31:0] foot_max_y;
        logic               foot_void;
        logic signed [31:0] near_min_x;
        logic signed [31:0] near_min_y;
        logic signed [31:0] near_max_x;
        logic signed [31:0] near_max_y;
        logic               near_void;
    } box_pair_t;

    typedef struct packed {
        logic signed [31:0] x0, x1, x2, x3, y0, y1, y2, y3;
        logic               fp;
        logic [30:0]        fl;
        logic               vp;
        logic [30:0]        vl;
    } segment_t;

    class box_scoreboard;
        box_pair_t pending_boxes[$];
        int mismatches;

        function automatic longint floor_frac(longint x);
            longint q;
            q = x / 65536;
            if (x % 65536 < 0) q -= 1;
            return q;
        endfunction

        function automatic longint eval_at(longint a[4], longint t);
            longint acc;
            acc = a[3];
            acc = floor_frac(acc * t) + a[2];
            acc = floor_frac(acc * t) + a[1];
            acc = floor_frac(acc * t) + a[0];
            return acc;
        endfunction

        function automatic void visit_point(longint a[4], longint num, longint den,
                                            ref longint lo, ref longint hi);
            longint v;
            if (den == 0) return;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            if (num < 0 || num > den) return;
            v = eval_at(a, (num * 65536) / den);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        endfunction

        function automatic longint root_floor(logic [63:0] n);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function automatic void axis_range(longint a[4], ref longint lo, ref longint hi);
            longint v1;
            logic signed [66:0] disc;
            logic [66:0] mag;
            v1 = a[0] + a[1] + a[2] + a[3];
            lo = (a[0] < v1) ? a[0] : v1;
            hi = (a[0] < v1) ? v1 : a[0];
            if (a[3] == 0) begin
                if (a[2] != 0) visit_point(a, -a[1], 2 * a[2], lo, hi);
                return;
            end
            disc = 67'(a[2]) * 67'(a[2]) - 67'sd3 * 67'(a[3]) * 67'(a[1]);
            mag = disc < 0 ? -disc : disc;
            if (mag <= 67'd107374) begin
                visit_point(a, -a[2], 3 * a[3], lo, hi);
            end else if (disc > 0) begin
                longint s;
                s = root_floor(mag[63:0]);
                visit_point(a, -a[2] + s, 3 * a[3], lo, hi);
                visit_point(a, -a[2] - s, 3 * a[3], lo, hi);
            end
        endfunction

        function automatic logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return SAT_MAX;
            if (v < -64'sd2147483648) return SAT_MIN;
            return v[31:0];
        endfunction

        function void note_segment(segment_t s);
            longint ax[4], ay[4], xl, xh, yl, yh, fl, vl;
            box_pair_t b;
            ax = '{s.x0, s.x1, s.x2, s.x3};
            ay = '{s.y0, s.y1, s.y2, s.y3};
            axis_range(ax, xl, xh);
            axis_range(ay, yl, yh);
            fl = s.fl;
            vl = s.vl;
            if (s.fp) begin
                b.foot_min_x = clamp32(xl - fl); b.foot_min_y = clamp32(yl - fl);
                b.foot_max_x = clamp32(xh + fl); b.foot_max_y = clamp32(yh + fl);
                b.foot_void = 0;
            end else begin
                b.foot_min_x = SAT_MAX; b.foot_min_y = SAT_MAX;
                b.foot_max_x = SAT_MIN; b.foot_max_y = SAT_MIN;
                b.foot_void = 1;
            end
            if (s.vp) begin
                b.near_min_x = clamp32(xl - vl); b.near_min_y = clamp32(yl - vl);
                b.near_max_x = clamp32(xh + vl); b.near_max_y = clamp32(yh + vl);
                b.near_void = 0;
            end else begin
                b.near_min_x = SAT_MAX; b.near_min_y = SAT_MAX;
                b.near_max_x = SAT_MIN; b.near_max_y = SAT_MIN;
                b.near_void = 1;
            end
            pending_boxes.push_back(b);
        endfunction

        function void check_boxes(box_pair_t got);
            box_pair_t want;
            if (pending_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item: %p", got);
                return;
            end
            want = pending_boxes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    segment_t seg = '0;
    logic o_stall, o_valid;
    box_pair_t got;
    box_scoreboard board = new();
    int cycles = 0;
    bit rx_hold = 0, quiet = 0;

    always #10 i_clk = ~i_clk;

    cubic_spline_bounding_profile_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_x_coef0(seg.x0), .i_x_coef1(seg.x1), .i_x_coef2(seg.x2), .i_x_coef3(seg.x3),
        .i_y_coef0(seg.y0), .i_y_coef1(seg.y1), .i_y_coef2(seg.y2), .i_y_coef3(seg.y3),
        .i_footprint_present(seg.fp), .i_footprint_length(seg.fl),
        .i_vicinity_present(seg.vp), .i_vicinity_length(seg.vl),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_foot_min_x(got.foot_min_x), .o_foot_min_y(got.foot_min_y),
        .o_foot_max_x(got.foot_max_x), .o_foot_max_y(got.foot_max_y),
        .o_foot_void(got.foot_void),
        .o_near_min_x(got.near_min_x), .o_near_min_y(got.near_min_y),
        .o_near_max_x(got.near_max_x), .o_near_max_y(got.near_max_y),
        .o_near_void(got.near_void)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("cubic_spline_bounding_profile_top regression: fail");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) board.check_boxes(got);
        if (i_rst_n && i_valid && !o_stall) board.note_segment(seg);
        i_stall <= rx_hold || (!quiet && $urandom_range(99) < 10);
    end

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(65536) - 32768;
            2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return $urandom_range(1) ? 32'd0 : 32'($urandom_range(8)) << 16;
            default: return 32'($signed(32'($urandom_range(6000)) - 3000)) <<< 8;
        endcase
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        s.x0 = pick_coef(); s.x1 = pick_coef(); s.x2 = pick_coef(); s.x3 = pick_coef();
        s.y0 = pick_coef(); s.y1 = pick_coef(); s.y2 = pick_coef(); s.y3 = pick_coef();
        if ($urandom_range(3) == 0) s.x3 = 0;
        if ($urandom_range(5) == 0) begin
            s.y3 = 32'sh0001_0000;
            s.y2 = -32'sh0003_0000;
            s.y1 = 32'sh0003_0000 + $signed(32'($urandom_range(3))) - 1;
        end
        s.fp = $urandom_range(7) != 0;
        s.vp = $urandom_range(7) != 0;
        if ($urandom_range(1)) s.fl = 31'($urandom_range(1 << 20));
        if ($urandom_range(1)) s.vl = 31'($urandom_range(1 << 20));
        return s;
    endfunction

    task automatic send_segment(segment_t s, bit gaps);
        while (gaps && !quiet && $urandom_range(99) < 10) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        seg <= s;
        i_valid <= 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending_boxes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        segment_t s;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        s = '0; send_segment(s, 0);
        s = '1; send_segment(s, 0);
        s = {32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             1'b1, 31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF};
        send_segment(s, 0);
        s = {32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
             1'b0, 31'h7FFF_FFFF, 1'b1, 31'd0};
        send_segment(s, 0);
        // Linear, quadratic with interior vertex, quadratic with vertex outside.
        s = {32'sh10000, 32'sh20000, 32'sh0, 32'sh0, -32'sh10000, 32'sh30000, 32'sh0,
             32'sh0, 1'b1, 31'h100, 1'b0, 31'h55};
        send_segment(s, 0);
        s = {32'sh0, 32'sh40000, -32'sh40000, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000,
             32'sh0, 1'b1, 31'h1000, 1'b1, 31'h8000};
        send_segment(s, 0);
        // Double root, band edge, negative discriminant, two interior roots.
        s = {32'sh0, 32'sh30000, -32'sh30000, 32'sh10000, 32'sh0, 32'sh30001,
             -32'sh30000, 32'sh10000, 1'b1, 31'h0, 1'b1, 31'h1};
        send_segment(s, 0);
        s = {32'sh0, 32'sh50000, 32'sh0, 32'sh10000, 32'sh0, 32'sh10000, -32'sh60000,
             32'sh40000, 1'b1, 31'h2, 1'b1, 31'h3};
        send_segment(s, 0);
        s = {32'sh0, -32'sh10000, 32'sh0, 32'sh40000, 32'sh0, 32'sh10000, 32'sh0,
             -32'sh40000, 1'b1, 31'h7FFF_FFFF, 1'b0, 31'h0};
        send_segment(s, 0);
        drain();

        for (int n = 0; n < 600; n++) begin
            quiet = (n >= 200 && n < 300);
            if (n == 400) begin
                drain();
                repeat (20) @(posedge i_clk);
            end
            send_segment(random_segment(), 1);
        end
        quiet = 0;
        drain();
        repeat (70) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_boxes.size() == 0)
            $display("cubic_spline_bounding_profile_top regression: pass");
        else
            $display("cubic_spline_bounding_profile_top regression: fail");
        $finish;
    end

    // The receiver holds off for a long stretch while items keep arriving.
    initial begin
        wait (cycles == 700);
        rx_hold = 1;
        repeat (300) @(posedge i_clk);
        rx_hold = 0;
    end
endmodule
